FILE: rtl/ssr_pkg.sv
// Shared types and constants for the stepper speed ramp generator.
// Used by ssr_div and by stepper_speed_ramp; depends on nothing else.
package ssr_pkg;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    // Item operations, carried in tuser.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    // Move modes. A start with the clear mode only resets the step count.
    localparam logic [1:0] MODE_ACCEL = 2'd0;
    localparam logic [1:0] MODE_TRAP  = 2'd1;
    localparam logic [1:0] MODE_CONST = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Trapezoid phases.
    localparam logic [1:0] PH_ACCEL = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_DECEL = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // Field widths.
    localparam int DLY_W = 32;
    localparam int CNT_W = 24;
    localparam int IDX_W = 25;

    // Serial divider: a 33-bit dividend (twice a delay) over a divisor of
    // up to 26 bits (the magnitude of 4n+1 for a 25-bit ramp index).
    localparam int DIV_QW = 33;
    localparam int DIV_DW = 26;

    // Beat widths.
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;

endpackage

FILE: rtl/ssr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ssr_pkg for the operand widths.
module ssr_div
    import ssr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_QW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_QW-1:0] o_quot
);

    localparam int CW = $clog2(DIV_QW + 1);

    logic [DIV_QW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dsr;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_fits;

    // The dividend shifts out of the top of r_quo while quotient bits
    // shift in at the bottom.
    assign w_trial = {r_rem, r_quo[DIV_QW-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_QW-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/stepper_speed_ramp.sv
// Stepper speed ramp generator: top level with joint state and sequencer.
// Depends on ssr_pkg and instantiates the serial divider ssr_div.
// Sequencing: an accepted item passes through S_PREP; a tick that updates the delay,
// or a trapezoid start, then waits in S_DIV for the bit-serial division in ssr_div;
// every item ends in S_DONE, which commits once the output register is free.
// Items are taken one at a time: the input stays closed until the commit.
// Reset: synchronous, active low; all joint state is cleared.
module stepper_speed_ramp
    import ssr_pkg::*;
#(
    parameter int NUM_JOINTS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Slave side. tdata from bit 0 up: joint[2:0], move_mode[4:3],
    // start_delay[36:5], floor_delay[68:37], goal_steps[92:69], zero pad.
    // tuser: operation[1:0].
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  logic [S_USER_W-1:0] i_s_axis_tuser,
    // Master side. tdata from bit 0 up: step_toggle[0], reload_valid[1],
    // reload_value[17:2], timer_halt[18], moving[19], steps_done[43:20],
    // zero pad.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    // Width of a joint index; at least one bit so a single joint still works.
    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // ------------------------------------------------------------------
    // Per-joint state. Each entry is a plain register; only the joint of
    // the item being worked on is read or written.
    // ------------------------------------------------------------------
    logic [DLY_W-1:0] r_delay_now    [NUM_JOINTS];
    logic [DLY_W-1:0] r_delay_floor  [NUM_JOINTS];
    logic [CNT_W-1:0] r_step_counter [NUM_JOINTS];
    logic [CNT_W-1:0] r_step_target  [NUM_JOINTS];
    logic [IDX_W-1:0] r_ramp_index   [NUM_JOINTS];
    logic [CNT_W-1:0] r_decel_at     [NUM_JOINTS];
    logic [IDX_W-1:0] r_decel_offset [NUM_JOINTS];
    logic [1:0]       r_axis_mode    [NUM_JOINTS];
    logic [1:0]       r_ramp_phase   [NUM_JOINTS];
    logic             r_running      [NUM_JOINTS];

    // Captured input beat.
    logic [1:0]       r_op;
    logic [2:0]       r_joint;
    logic [1:0]       r_mode;
    logic [DLY_W-1:0] r_d0;
    logic [DLY_W-1:0] r_fl;
    logic [CNT_W-1:0] r_goal;

    t_state r_state;
    t_state n_state;

    logic                r_m_tvalid;
    logic [M_DATA_W-1:0] r_m_tdata;

    // Sequencer outputs.
    logic w_accept;
    logic w_div_start;
    logic w_commit;
    logic w_out_free;

    // Divider connections.
    logic              w_div_done;
    logic [DIV_QW-1:0] w_quot;
    logic [DIV_QW-1:0] w_dividend;
    logic [DIV_DW-1:0] w_divisor;
    logic              w_need_div;

    // Current entry of the addressed joint.
    logic [JW-1:0]    w_jidx;
    logic             w_in_range;
    logic [DLY_W-1:0] w_cur_delay;
    logic [DLY_W-1:0] w_cur_floor;
    logic [CNT_W-1:0] w_cur_cnt;
    logic [CNT_W-1:0] w_cur_target;
    logic [IDX_W-1:0] w_cur_idx;
    logic [CNT_W-1:0] w_cur_decel_at;
    logic [IDX_W-1:0] w_cur_decel_off;
    logic [1:0]       w_cur_mode;
    logic [1:0]       w_cur_phase;
    logic             w_cur_run;

    // Ramp index after this step, and |4n+1| for it.
    logic [IDX_W-1:0] w_n_next;
    logic [IDX_W+1:0] w_m;
    logic [IDX_W+1:0] w_m_abs;
    logic [CNT_W+1:0] w_goal3;
    logic [CNT_W-1:0] w_off;
    logic [DLY_W-1:0] w_upd_delay;
    logic [CNT_W-1:0] w_cnt_inc;

    // Next values of the addressed entry.
    logic [DLY_W-1:0] n_delay_now;
    logic [DLY_W-1:0] n_delay_floor;
    logic [CNT_W-1:0] n_step_counter;
    logic [CNT_W-1:0] n_step_target;
    logic [IDX_W-1:0] n_ramp_index;
    logic [CNT_W-1:0] n_decel_at;
    logic [IDX_W-1:0] n_decel_offset;
    logic [1:0]       n_axis_mode;
    logic [1:0]       n_ramp_phase;
    logic             n_running;

    // Result fields.
    logic        w_tog;
    logic        w_rv;
    logic [15:0] w_rval;
    logic        w_halt;

    // Delay update d -/+ floor(2d/|4n+1|); the sum saturates on the way up,
    // and a zero ramp index leaves the delay as it is.
    function automatic logic [DLY_W-1:0] ramp_update(
        input logic [DLY_W-1:0]  d,
        input logic [IDX_W-1:0]  n,
        input logic [DIV_QW-1:0] q
    );
        logic [DLY_W+1:0] s;
        s = {2'b00, d} + {1'b0, q};
        if (n == '0) begin
            return d;
        end else if (!n[IDX_W-1]) begin
            return d - q[DLY_W-1:0];
        end else if (s[DLY_W+1:DLY_W] != 2'b00) begin
            return '1;
        end else begin
            return s[DLY_W-1:0];
        end
    endfunction

    // Timer period: integer part of the delay, saturated to 16 bits.
    function automatic logic [15:0] reload_of(input logic [DLY_W-1:0] d);
        logic [DLY_W-1:0] v;
        v = d >> FRAC_BITS;
        if (v > DLY_W'(16'hFFFF)) begin
            return 16'hFFFF;
        end else begin
            return v[15:0];
        end
    endfunction

    assign w_jidx     = JW'(r_joint);
    assign w_in_range = (32'(r_joint) < NUM_JOINTS);

    assign w_cur_delay     = r_delay_now[w_jidx];
    assign w_cur_floor     = r_delay_floor[w_jidx];
    assign w_cur_cnt       = r_step_counter[w_jidx];
    assign w_cur_target    = r_step_target[w_jidx];
    assign w_cur_idx       = r_ramp_index[w_jidx];
    assign w_cur_decel_at  = r_decel_at[w_jidx];
    assign w_cur_decel_off = r_decel_offset[w_jidx];
    assign w_cur_mode      = r_axis_mode[w_jidx];
    assign w_cur_phase     = r_ramp_phase[w_jidx];
    assign w_cur_run       = r_running[w_jidx];

    // Every delay-updating tick advances the ramp index before the update.
    assign w_n_next  = w_cur_idx + 1'b1;
    assign w_m       = {w_n_next, 2'b01};
    assign w_m_abs   = w_n_next[IDX_W-1] ? (~w_m + 1'b1) : w_m;
    assign w_cnt_inc = w_cur_cnt + 1'b1;

    // The deceleration offset 0.6*goal is taken exactly as floor(3*goal/5)
    // on the same serial divider.
    assign w_goal3 = {1'b0, r_goal, 1'b0} + {2'b00, r_goal};
    assign w_off   = w_quot[CNT_W-1:0];

    assign w_upd_delay = ramp_update(w_cur_delay, w_n_next, w_quot);

    // Decide whether the item needs a division, and with what operands.
    always_comb begin
        w_need_div = 1'b0;
        w_dividend = {w_cur_delay, 1'b0};
        w_divisor  = w_m_abs[DIV_DW-1:0];
        if (w_in_range) begin
            if (r_op == OP_START && r_mode == MODE_TRAP) begin
                w_need_div = 1'b1;
                w_dividend = DIV_QW'(w_goal3);
                w_divisor  = DIV_DW'(5);
            end else if (r_op == OP_TICK && w_cur_run && w_n_next != '0) begin
                if (w_cur_mode == MODE_ACCEL) begin
                    w_need_div = 1'b1;
                end else if (w_cur_mode == MODE_TRAP &&
                             (w_cur_phase == PH_ACCEL || w_cur_phase == PH_DECEL)) begin
                    w_need_div = 1'b1;
                end
            end
        end
    end

    ssr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ------------------------------------------------------------------
    // Item behavior: next entry values and result fields, applied at the
    // commit cycle once the quotient (if any) is ready.
    // ------------------------------------------------------------------
    always_comb begin
        n_delay_now    = w_cur_delay;
        n_delay_floor  = w_cur_floor;
        n_step_counter = w_cur_cnt;
        n_step_target  = w_cur_target;
        n_ramp_index   = w_cur_idx;
        n_decel_at     = w_cur_decel_at;
        n_decel_offset = w_cur_decel_off;
        n_axis_mode    = w_cur_mode;
        n_ramp_phase   = w_cur_phase;
        n_running      = w_cur_run;
        w_tog          = 1'b0;
        w_rv           = 1'b0;
        w_rval         = '0;
        w_halt         = 1'b0;

        unique case (r_op)
            OP_START: begin
                n_step_counter = '0;
                if (r_mode != MODE_CLEAR) begin
                    n_delay_now = r_d0;
                    n_axis_mode = r_mode;
                    n_running   = 1'b1;
                    if (r_mode != MODE_CONST) begin
                        n_delay_floor = r_fl;
                        n_ramp_index  = '0;
                    end
                    if (r_mode == MODE_TRAP) begin
                        n_ramp_phase   = PH_ACCEL;
                        n_step_target  = r_goal;
                        n_decel_offset = IDX_W'(0) - {1'b0, w_off};
                        n_decel_at     = r_goal - w_off;
                    end
                    w_rv   = 1'b1;
                    w_rval = reload_of(r_d0);
                end
            end
            OP_STOP: begin
                n_running = 1'b0;
                w_halt    = 1'b1;
            end
            OP_TICK: begin
                if (!w_cur_run) begin
                    w_halt = 1'b1;
                end else if (w_cur_mode == MODE_ACCEL) begin
                    w_tog          = 1'b1;
                    n_step_counter = w_cnt_inc;
                    n_ramp_index   = w_n_next;
                    n_delay_now    = w_upd_delay;
                    w_rv           = 1'b1;
                    w_rval         = reload_of(w_upd_delay);
                    if (w_upd_delay <= w_cur_floor) begin
                        w_halt    = 1'b1;
                        n_running = 1'b0;
                    end
                end else if (w_cur_mode == MODE_TRAP) begin
                    w_tog = 1'b1;
                    unique case (w_cur_phase)
                        PH_ACCEL: begin
                            n_step_counter = w_cnt_inc;
                            n_ramp_index   = w_n_next;
                            n_delay_now    = w_upd_delay;
                            w_rv           = 1'b1;
                            w_rval         = reload_of(w_upd_delay);
                            if (w_upd_delay <= w_cur_floor) begin
                                n_ramp_phase = PH_RUN;
                            end
                            // Reaching the deceleration point wins over
                            // reaching full speed on the same step.
                            if (w_cnt_inc >= w_cur_decel_at) begin
                                n_ramp_index = w_cur_decel_off;
                                n_ramp_phase = PH_DECEL;
                            end
                        end
                        PH_RUN: begin
                            n_step_counter = w_cnt_inc;
                            n_delay_now    = w_cur_floor;
                            if (w_cnt_inc >= w_cur_decel_at) begin
                                n_ramp_index = w_cur_decel_off;
                                n_ramp_phase = PH_DECEL;
                            end
                        end
                        PH_DECEL: begin
                            // The reload carries the delay from before the
                            // update.
                            n_step_counter = w_cnt_inc;
                            n_ramp_index   = w_n_next;
                            w_rv           = 1'b1;
                            w_rval         = reload_of(w_cur_delay);
                            n_delay_now    = w_upd_delay;
                            if (w_cnt_inc >= w_cur_target) begin
                                n_ramp_phase = PH_STOP;
                            end
                        end
                        PH_STOP: begin
                            w_halt    = 1'b1;
                            n_running = 1'b0;
                        end
                        default: begin
                            w_halt = 1'b0;
                        end
                    endcase
                end else if (w_cur_mode == MODE_CONST) begin
                    w_tog = 1'b1;
                end
            end
            OP_STATUS: begin
                w_halt = 1'b0;
            end
            default: begin
                w_halt = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: capture, set up the division, wait for it, commit.
    // ------------------------------------------------------------------
    assign w_out_free = !r_m_tvalid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = w_need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_accept        = (r_state == S_IDLE) && i_s_axis_tvalid;
        w_div_start     = (r_state == S_PREP) && w_need_div;
        w_commit        = (r_state == S_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_s_axis_tuser[1:0];
            r_joint <= i_s_axis_tdata[2:0];
            r_mode  <= i_s_axis_tdata[4:3];
            r_d0    <= i_s_axis_tdata[36:5];
            r_fl    <= i_s_axis_tdata[68:37];
            r_goal  <= i_s_axis_tdata[92:69];
        end
    end

    // Joint state: cleared by reset, written back at commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_delay_now[k]    <= '0;
                r_delay_floor[k]  <= '0;
                r_step_counter[k] <= '0;
                r_step_target[k]  <= '0;
                r_ramp_index[k]   <= '0;
                r_decel_at[k]     <= '0;
                r_decel_offset[k] <= '0;
                r_axis_mode[k]    <= MODE_ACCEL;
                r_ramp_phase[k]   <= PH_ACCEL;
                r_running[k]      <= 1'b0;
            end
        end else if (w_commit && w_in_range) begin
            r_delay_now[w_jidx]    <= n_delay_now;
            r_delay_floor[w_jidx]  <= n_delay_floor;
            r_step_counter[w_jidx] <= n_step_counter;
            r_step_target[w_jidx]  <= n_step_target;
            r_ramp_index[w_jidx]   <= n_ramp_index;
            r_decel_at[w_jidx]     <= n_decel_at;
            r_decel_offset[w_jidx] <= n_decel_offset;
            r_axis_mode[w_jidx]    <= n_axis_mode;
            r_ramp_phase[w_jidx]   <= n_ramp_phase;
            r_running[w_jidx]      <= n_running;
        end
    end

    // Output register: the result beat waits here while the next item is
    // accepted and worked on. An out-of-range joint yields an all-zero beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_commit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            if (w_in_range) begin
                r_m_tdata <= {4'b0000, n_step_counter, n_running, w_halt,
                              w_rval, w_rv, w_tog};
            end else begin
                r_m_tdata <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

`ifndef SYNTH
    // One item at a time: an accepted beat closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in progress");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    // A stalled result beat holds the commit back.
    a_commit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_m_axis_tvalid && !i_m_axis_tready)
        |=> (r_state == S_DONE))
        else $error("commit passed over a waiting result beat");

    // Without a reload the reload value reads zero.
    a_reload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[1]) |-> (o_m_axis_tdata[17:2] == '0))
        else $error("reload value set without a reload");
`endif

endmodule

FILE: tb/sv/tb_stepper_speed_ramp.sv
`timescale 1ns / 100ps
// Self-checking testbench for stepper_speed_ramp: directed and random start, tick, stop
// and status beats, each result beat checked against a per-joint speed ramp predictor.
// Depends on ssr_pkg and the stepper_speed_ramp RTL.
module tb_stepper_speed_ramp
    import ssr_pkg::*;
();

    localparam int NJ             = 6;
    localparam int FRAC           = 16;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat accepted on either side
    localparam int DRAIN_CYCLES   = 50;    // idle margin after the last result beat

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  joint;
        logic [1:0]  mode;
        logic [31:0] start_delay;
        logic [31:0] floor_delay;
        logic [23:0] goal;
    } t_cmd;

    typedef struct {
        logic        toggle;
        logic        reload_valid;
        logic [15:0] reload_value;
        logic        halt;
        logic        moving;
        logic [23:0] steps;
    } t_resp;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata;
    logic [S_USER_W-1:0] i_s_axis_tuser;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [M_DATA_W-1:0] o_m_axis_tdata;

    // Predicted state of every joint, updated when a command beat is accepted.
    logic [31:0] mdl_delay     [NJ];
    logic [31:0] mdl_floor     [NJ];
    logic [23:0] mdl_count     [NJ];
    logic [23:0] mdl_target    [NJ];
    logic [23:0] mdl_decel_at  [NJ];
    logic [24:0] mdl_index     [NJ];
    logic [24:0] mdl_decel_off [NJ];
    logic [1:0]  mdl_mode      [NJ];
    logic [1:0]  mdl_phase     [NJ];
    logic        mdl_run       [NJ];

    t_resp joint_response_q[$];

    bit sender_gaps      = 1'b1;
    bit receiver_stalls  = 1'b1;
    bit hold_off_request = 1'b0;

    int mismatches     = 0;
    int cmds_sent      = 0;
    int starts_sent    = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int hold_offs_done = 0;
    int idle_cycles    = 0;

    stepper_speed_ramp #(
        .NUM_JOINTS (NJ),
        .FRAC_BITS  (FRAC)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One ramp update: d - 2d/(4n+1) for positive 4n+1, d + 2d/|4n+1| saturated to
    // all ones for negative 4n+1, and no change at all when n is zero.
    function automatic logic [31:0] ramp_next(logic [31:0] d, logic [24:0] idx);
        longint n;
        longint m;
        longint unsigned twice;
        longint unsigned q;
        longint unsigned s;
        n = $signed(idx);
        if (n == 0) return d;
        m = 4 * n + 1;
        twice = {31'b0, d, 1'b0};
        if (m > 0) begin
            q = twice / $unsigned(m);
            return d - q[31:0];
        end
        q = twice / $unsigned(-m);
        s = {32'b0, d} + q;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Timer period: integer part of the delay, saturated to 16 bits.
    function automatic logic [15:0] reload_of_delay(logic [31:0] d);
        logic [31:0] v;
        v = d >> FRAC;
        return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // A counted step advances both the ramp index and the step count.
    function automatic void count_step(int j);
        mdl_index[j] = mdl_index[j] + 25'd1;
        mdl_count[j] = mdl_count[j] + 24'd1;
    endfunction

    // Applies one command to the joint model and returns the result beat it causes.
    function automatic t_resp predict_joint_response(t_cmd c);
        t_resp       r;
        int          j;
        logic [63:0] off;
        r.toggle       = 1'b0;
        r.reload_valid = 1'b0;
        r.reload_value = '0;
        r.halt         = 1'b0;
        r.moving       = 1'b0;
        r.steps        = '0;
        // Joints that do not exist are ignored and answer with an all-zero beat.
        if (c.joint >= NJ) return r;
        j = c.joint;
        case (c.op)
            OP_START: begin
                mdl_count[j] = '0;
                if (c.mode != MODE_CLEAR) begin
                    mdl_delay[j] = c.start_delay;
                    mdl_mode[j]  = c.mode;
                    mdl_run[j]   = 1'b1;
                    if (c.mode != MODE_CONST) begin
                        mdl_floor[j] = c.floor_delay;
                        mdl_index[j] = '0;
                    end
                    if (c.mode == MODE_TRAP) begin
                        // Deceleration covers trunc(0.6 * goal) steps at the end.
                        off               = (64'(c.goal) * 3) / 5;
                        mdl_phase[j]      = PH_ACCEL;
                        mdl_target[j]     = c.goal;
                        mdl_decel_off[j]  = 25'(64'd0 - off);
                        mdl_decel_at[j]   = c.goal - off[23:0];
                    end
                    r.reload_valid = 1'b1;
                    r.reload_value = reload_of_delay(c.start_delay);
                end
            end
            OP_STOP: begin
                mdl_run[j] = 1'b0;
                r.halt     = 1'b1;
            end
            OP_TICK: begin
                if (!mdl_run[j]) begin
                    r.halt = 1'b1;
                end else if (mdl_mode[j] == MODE_ACCEL) begin
                    r.toggle = 1'b1;
                    count_step(j);
                    mdl_delay[j]   = ramp_next(mdl_delay[j], mdl_index[j]);
                    r.reload_valid = 1'b1;
                    r.reload_value = reload_of_delay(mdl_delay[j]);
                    if (mdl_delay[j] <= mdl_floor[j]) begin
                        r.halt     = 1'b1;
                        mdl_run[j] = 1'b0;
                    end
                end else if (mdl_mode[j] == MODE_TRAP) begin
                    r.toggle = 1'b1;
                    case (mdl_phase[j])
                        PH_ACCEL: begin
                            count_step(j);
                            mdl_delay[j]   = ramp_next(mdl_delay[j], mdl_index[j]);
                            r.reload_valid = 1'b1;
                            r.reload_value = reload_of_delay(mdl_delay[j]);
                            if (mdl_delay[j] <= mdl_floor[j]) mdl_phase[j] = PH_RUN;
                            if (mdl_count[j] >= mdl_decel_at[j]) begin
                                mdl_index[j] = mdl_decel_off[j];
                                mdl_phase[j] = PH_DECEL;
                            end
                        end
                        PH_RUN: begin
                            // Cruising: the count moves but the ramp index does not.
                            mdl_count[j] = mdl_count[j] + 24'd1;
                            mdl_delay[j] = mdl_floor[j];
                            if (mdl_count[j] >= mdl_decel_at[j]) begin
                                mdl_index[j] = mdl_decel_off[j];
                                mdl_phase[j] = PH_DECEL;
                            end
                        end
                        PH_DECEL: begin
                            // The reload carries the delay from before this update.
                            count_step(j);
                            r.reload_valid = 1'b1;
                            r.reload_value = reload_of_delay(mdl_delay[j]);
                            mdl_delay[j]   = ramp_next(mdl_delay[j], mdl_index[j]);
                            if (mdl_count[j] >= mdl_target[j]) mdl_phase[j] = PH_STOP;
                        end
                        default: begin
                            r.halt     = 1'b1;
                            mdl_run[j] = 1'b0;
                        end
                    endcase
                end else if (mdl_mode[j] == MODE_CONST) begin
                    // Constant speed toggles the pin but counts nothing.
                    r.toggle = 1'b1;
                end
            end
            default: ;  // a status query changes nothing
        endcase
        r.moving = mdl_run[j];
        r.steps  = mdl_count[j];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    function automatic t_cmd make_cmd(logic [1:0] op, logic [2:0] joint, logic [1:0] mode,
                                      logic [31:0] d0, logic [31:0] fl, logic [23:0] goal);
        t_cmd c;
        c.op          = op;
        c.joint       = joint;
        c.mode        = mode;
        c.start_delay = d0;
        c.floor_delay = fl;
        c.goal        = goal;
        return c;
    endfunction

    // Sends one command beat, optionally after a random gap, and records the result
    // it must cause once the beat is accepted.
    task automatic send_cmd(input t_cmd c);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c.op;
        i_s_axis_tdata  <= {3'b0, c.goal, c.floor_delay, c.start_delay, c.mode, c.joint};
        do @(posedge i_clk); while (!o_s_axis_tready);
        joint_response_q.push_back(predict_joint_response(c));
        cmds_sent++;
        if (c.op == OP_START) starts_sent++;
        if (c.op == OP_TICK) ticks_sent++;
    endtask

    // Holds the command side quiet until every predicted result has come back.
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (joint_response_q.size() != 0);
    endtask

    // Mostly well-formed traffic: idle joints get started with shaped parameters and
    // moving joints get ticks, with the odd status query, stop or restart. About one
    // beat in ten is noise with every field random, invalid joints included.
    function automatic t_cmd next_random_cmd();
        t_cmd c;
        int   j;
        int   pick;
        int   sel;
        c = make_cmd(OP_TICK, 3'd0, MODE_ACCEL, $urandom, $urandom, 24'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            c.op    = 2'($urandom);
            c.joint = 3'($urandom);
            c.mode  = 2'($urandom);
            return c;
        end
        j = $urandom_range(0, NJ - 1);
        c.joint = 3'(j);
        if ((!mdl_run[j] && pick < 85) || (mdl_run[j] && pick >= 98)) begin
            c.op = OP_START;
            sel  = $urandom_range(0, 19);
            c.mode = (sel < 8) ? MODE_TRAP : (sel < 14) ? MODE_ACCEL :
                     (sel < 18) ? MODE_CONST : MODE_CLEAR;
            c.start_delay = $urandom >> $urandom_range(0, 15);
            // A floor a few octaves below the start keeps acceleration short.
            if ($urandom_range(0, 7) != 0)
                c.floor_delay = c.start_delay >> $urandom_range(0, 3);
            if ($urandom_range(0, 9) != 0)
                c.goal = 24'($urandom_range(0, 48));
        end else if (!mdl_run[j]) begin
            c.op = ($urandom_range(0, 2) == 0) ? OP_STOP :
                   ($urandom_range(0, 1) == 0) ? OP_STATUS : OP_TICK;
        end else begin
            c.op = (pick < 92) ? OP_TICK : (pick < 96) ? OP_STATUS : OP_STOP;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s in result %0d: got 0x%0h, expected 0x%0h",
                     $realtime, what, results_seen, got, want);
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // Receiver: random stalls, or one long hold-off when the test asks for it. The
    // hold-off is timed here so the command side can keep offering beats meanwhile.
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_request = 1'b0;
                hold_offs_done++;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (joint_response_q.size() == 0) begin
                report_mismatch("unexpected result beat", o_m_axis_tdata, 0);
            end else begin
                want = joint_response_q.pop_front();
                check_field("step_toggle",  o_m_axis_tdata[0],     want.toggle);
                check_field("reload_valid", o_m_axis_tdata[1],     want.reload_valid);
                check_field("reload_value", o_m_axis_tdata[17:2],  want.reload_value);
                check_field("timer_halt",   o_m_axis_tdata[18],    want.halt);
                check_field("moving",       o_m_axis_tdata[19],    want.moving);
                check_field("steps_done",   o_m_axis_tdata[43:20], want.steps);
                check_field("tdata pad",    o_m_axis_tdata[47:44], 0);
            end
        end
    end

    // Watchdog: the run is hung if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat accepted for %0d cycles, %0d results pending",
                         idle_cycles, joint_response_q.size());
                $display("tb_stepper_speed_ramp: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries, ticks and stops on idle joints, invalid joint numbers, and a start that
    // only clears the step count.
    task automatic test_idle_joint_ops();
        send_cmd(make_cmd(OP_STATUS, 3'd0, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_TICK,   3'd0, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_STOP,   3'd5, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_TICK,   3'd6, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_START,  3'd7, MODE_TRAP, '1, '1, '1));
        send_cmd(make_cmd(OP_START,  3'd1, MODE_CLEAR, 32'h0123_4567, '1, 24'h00_00FF));
    endtask

    // Accelerate-only moves at the delay extremes: the slowest start with a zero
    // floor, and a zero start delay that stops on its very first step.
    task automatic test_accel_extremes();
        send_cmd(make_cmd(OP_START, 3'd0, MODE_ACCEL, '1, '0, '0));
        send_cmd(make_cmd(OP_TICK,  3'd0, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_START, 3'd2, MODE_ACCEL, '0, '1, '0));
        send_cmd(make_cmd(OP_TICK,  3'd2, MODE_ACCEL, '0, '0, '0));
    endtask

    // Trapezoids: a zero goal that decelerates at once, and a short goal from maximal
    // delay that decelerates back up to all ones and ends with a skipped update at n=0.
    task automatic test_trapezoid_extremes();
        send_cmd(make_cmd(OP_START, 3'd3, MODE_TRAP, 32'hFFFF_0000, 32'h0001_0000, '0));
        repeat (3) send_cmd(make_cmd(OP_TICK, 3'd3, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_START, 3'd4, MODE_TRAP, '1, '0, 24'd5));
        repeat (6) send_cmd(make_cmd(OP_TICK, 3'd4, MODE_ACCEL, '0, '0, '0));
    endtask

    // Constant speed: ticks toggle without counting until a stop arrives.
    task automatic test_constant_speed();
        send_cmd(make_cmd(OP_START, 3'd5, MODE_CONST, 32'h8000_0001, '1, '1));
        send_cmd(make_cmd(OP_TICK,  3'd5, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_STOP,  3'd5, MODE_ACCEL, '0, '0, '0));
        send_cmd(make_cmd(OP_TICK,  3'd5, MODE_ACCEL, '0, '0, '0));
    endtask

    // Long random traffic; idling on both sides is switched on and off in stretches.
    task automatic test_random_moves(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            send_cmd(next_random_cmd());
        end
    endtask

    // The receiver holds off for a long stretch while commands keep coming, so the
    // block stalls its input; then the command side waits for every result.
    task automatic test_backpressure();
        sender_gaps      = 1'b0;
        hold_off_request = 1'b1;
        repeat (30) send_cmd(next_random_cmd());
        wait_results_drained();
    endtask

    // Back-to-back traffic with no idling at all on either side.
    task automatic test_full_rate_tail();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (200) send_cmd(next_random_cmd());
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_TICK;
        // The model starts from the same all-zero state that reset gives the block.
        for (int j = 0; j < NJ; j++) begin
            mdl_delay[j]     = '0;
            mdl_floor[j]     = '0;
            mdl_count[j]     = '0;
            mdl_target[j]    = '0;
            mdl_decel_at[j]  = '0;
            mdl_index[j]     = '0;
            mdl_decel_off[j] = '0;
            mdl_mode[j]      = MODE_ACCEL;
            mdl_phase[j]     = PH_ACCEL;
            mdl_run[j]       = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_joint_ops();
        test_accel_extremes();
        test_trapezoid_extremes();
        test_constant_speed();
        test_random_moves(1050);
        test_backpressure();
        test_full_rate_tail();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands (%0d starts, %0d ticks) on valid and invalid joints,",
                 cmds_sent, starts_sent, ticks_sent);
        $display("  %0d result beats checked, %0d long receiver hold-offs, %0d mismatches.",
                 results_seen, hold_offs_done, mismatches);
        if (mismatches == 0) begin
            $display("tb_stepper_speed_ramp: PASS");
        end else begin
            $display("tb_stepper_speed_ramp: FAIL");
        end
        $finish;
    end

endmodule

FILE: stepper_speed_ramp.f
rtl/ssr_pkg.sv
rtl/ssr_div.sv
rtl/stepper_speed_ramp.sv
tb/sv/tb_stepper_speed_ramp.sv
